>>> rtl/core/dhht_pkg.sv
// Shared types and constants for the dual heater hysteresis thermostat.
// Holds field widths, reset values, register indexes and stream field positions.
// No dependencies.
package dhht_pkg;

    localparam int SAMPLE_W = 10;
    localparam int TEMP_W   = 9;
    localparam int LEVEL_W  = 8;
    localparam int CFG_W    = 9;
    localparam int CFG_IDX_W = 3;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEAT_ONE_ON_BELOW  = 3'd0,
        REG_HEAT_ONE_OFF_ABOVE = 3'd1,
        REG_HEAT_TWO_ON_BELOW  = 3'd2,
        REG_HEAT_TWO_OFF_ABOVE = 3'd3,
        REG_LIQUID_MINIMUM     = 3'd4
    } cfg_reg_t;

    // Scan order of the converter channels.
    typedef enum logic [1:0] {
        CH_LEVEL_ONE = 2'd0,
        CH_LEVEL_TWO = 2'd1,
        CH_TEMP_ONE  = 2'd2,
        CH_TEMP_TWO  = 2'd3
    } chan_t;

    localparam logic [TEMP_W-1:0]  HEAT_ONE_ON_RST  = 9'd46;
    localparam logic [TEMP_W-1:0]  HEAT_ONE_OFF_RST = 9'd48;
    localparam logic [TEMP_W-1:0]  HEAT_TWO_ON_RST  = 9'd20;
    localparam logic [TEMP_W-1:0]  HEAT_TWO_OFF_RST = 9'd24;
    localparam logic [LEVEL_W-1:0] LIQUID_MIN_RST   = 8'd70;
    localparam logic [LEVEL_W-1:0] LEVEL_RST        = 8'd255;

    // sample*45/100 equals sample*9/20. Division by 20 is done as a multiply
    // by ceil(2^16/20) = 3277 and a 16-bit shift, exact for sample*9 < 2^14.
    localparam int PROD_W = 25;
    localparam int SCALE_SHIFT = 16;
    localparam logic [PROD_W-1:0] TEMP_SCALE_MUL = 25'd29493;
    localparam logic [TEMP_W-1:0] TEMP_OFFSET    = 9'd44;
    localparam logic [TEMP_W-1:0] TEMP_MAX       = 9'd416;

    // Result item field positions in m_axis_tdata.
    localparam int H_ONE_POS = 0;
    localparam int H_TWO_POS = 1;
    localparam int CH_LSB    = 2;
    localparam int T_ONE_LSB = 4;
    localparam int T_TWO_LSB = 13;
    localparam int L_ONE_LSB = 22;
    localparam int L_TWO_LSB = 30;

endpackage

>>> rtl/core/dual_heater_hysteresis_thermostat.sv
// An accepted sample goes through the input register, then the result register.
// Throughput: one sample per cycle while results are taken; the channel state is
// updated in the single compute stage between the input and result registers.
// Reset: asynchronous, active low; scan starts at level one, levels read 255,
// temperatures 0, both heaters off, thresholds at their default values.
// Depends on dhht_pkg.
module dual_heater_hysteresis_thermostat
    import dhht_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // [9:0] sample, [15:10] zero
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [0] heater_one_on, [1] heater_two_on, [3:2] next_channel,
    // [12:4] temperature_one, [21:13] temperature_two,
    // [29:22] level_one, [37:30] level_two, [39:38] zero
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    logic [TEMP_W-1:0]  heat_one_on_reg, heat_one_off_reg;
    logic [TEMP_W-1:0]  heat_two_on_reg, heat_two_off_reg;
    logic [LEVEL_W-1:0] liquid_min_reg;

    chan_t              scan_channel_reg, scan_channel_next;
    logic [LEVEL_W-1:0] level_one_reg, level_one_next;
    logic [LEVEL_W-1:0] level_two_reg, level_two_next;
    logic [TEMP_W-1:0]  temp_one_reg, temp_one_next;
    logic [TEMP_W-1:0]  temp_two_reg, temp_two_next;
    logic               heater_one_reg, heater_one_next;
    logic               heater_two_reg, heater_two_next;

    logic                in_valid_reg;
    logic [SAMPLE_W-1:0] in_sample_reg;
    logic                out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic                advance;
    logic                step;
    logic [PROD_W-1:0]   scale_prod;
    logic [TEMP_W-1:0]   scaled;
    logic [TEMP_W-1:0]   converted;
    logic [TEMP_W-1:0]   old_temp;
    logic [TEMP_W+1:0]   filt_sum;
    logic [TEMP_W-1:0]   new_temp;

    function automatic logic hysteresis(
        input logic               cur,
        input logic [TEMP_W-1:0]  temp,
        input logic [TEMP_W-1:0]  on_below,
        input logic [TEMP_W-1:0]  off_above,
        input logic [LEVEL_W-1:0] level,
        input logic [LEVEL_W-1:0] level_min
    );
        logic res;
        res = cur;
        // The off conditions come last so that they win over switching on.
        if (temp < on_below)
            res = 1'b1;
        if (temp > off_above)
            res = 1'b0;
        if (level < level_min)
            res = 1'b0;
        return res;
    endfunction

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        scale_prod = PROD_W'(in_sample_reg) * TEMP_SCALE_MUL;
        scaled     = scale_prod[SCALE_SHIFT +: TEMP_W];
        converted  = (scaled > TEMP_OFFSET) ? (scaled - TEMP_OFFSET) : '0;
        old_temp   = (scan_channel_reg == CH_TEMP_ONE) ? temp_one_reg : temp_two_reg;
        filt_sum   = {1'b0, old_temp, 1'b0} + {2'b00, old_temp} + {2'b00, converted};
        // A zero stored value means nothing measured yet, so no filtering.
        new_temp   = (old_temp == '0) ? converted : filt_sum[TEMP_W+1:2];
    end

    always_comb
    begin
        level_one_next    = level_one_reg;
        level_two_next    = level_two_reg;
        temp_one_next     = temp_one_reg;
        temp_two_next     = temp_two_reg;
        scan_channel_next = chan_t'(scan_channel_reg + 2'd1);
        unique case (scan_channel_reg)
            CH_LEVEL_ONE: level_one_next = in_sample_reg[SAMPLE_W-1:2];
            CH_LEVEL_TWO: level_two_next = in_sample_reg[SAMPLE_W-1:2];
            CH_TEMP_ONE:  temp_one_next  = new_temp;
            CH_TEMP_TWO:  temp_two_next  = new_temp;
        endcase
        heater_one_next = hysteresis(heater_one_reg, temp_one_next, heat_one_on_reg,
                                     heat_one_off_reg, level_one_next, liquid_min_reg);
        heater_two_next = hysteresis(heater_two_reg, temp_two_next, heat_two_on_reg,
                                     heat_two_off_reg, level_two_next, liquid_min_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heat_one_on_reg  <= HEAT_ONE_ON_RST;
            heat_one_off_reg <= HEAT_ONE_OFF_RST;
            heat_two_on_reg  <= HEAT_TWO_ON_RST;
            heat_two_off_reg <= HEAT_TWO_OFF_RST;
            liquid_min_reg   <= LIQUID_MIN_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_HEAT_ONE_ON_BELOW:  heat_one_on_reg  <= cfg_data;
                REG_HEAT_ONE_OFF_ABOVE: heat_one_off_reg <= cfg_data;
                REG_HEAT_TWO_ON_BELOW:  heat_two_on_reg  <= cfg_data;
                REG_HEAT_TWO_OFF_ABOVE: heat_two_off_reg <= cfg_data;
                REG_LIQUID_MINIMUM:     liquid_min_reg   <= cfg_data[LEVEL_W-1:0];
                default:                ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            scan_channel_reg <= CH_LEVEL_ONE;
            level_one_reg    <= LEVEL_RST;
            level_two_reg    <= LEVEL_RST;
            temp_one_reg     <= '0;
            temp_two_reg     <= '0;
            heater_one_reg   <= 1'b0;
            heater_two_reg   <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (step)
            begin
                scan_channel_reg <= scan_channel_next;
                level_one_reg    <= level_one_next;
                level_two_reg    <= level_two_next;
                temp_one_reg     <= temp_one_next;
                temp_two_reg     <= temp_two_next;
                heater_one_reg   <= heater_one_next;
                heater_two_reg   <= heater_two_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_sample_reg <= s_axis_tdata[SAMPLE_W-1:0];
        if (step)
            out_data_reg <= {2'b00, level_two_next, level_one_next, temp_two_next,
                             temp_one_next, scan_channel_next, heater_two_next,
                             heater_one_next};
    end

endmodule

>>> rtl/core/dhht_checker.sv
// Port-level checks for the dual heater hysteresis thermostat, bound to its top level.
// Depends on dhht_pkg and on the port list of dual_heater_hysteresis_thermostat.
module dhht_checker
    import dhht_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata
);

    logic m_take;
    assign m_take = m_axis_tvalid && m_axis_tready;

    // A stalled result item holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    // With no result waiting, the input side must be open.
    a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // Consecutive result items step the scan by one channel.
    a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
        m_take ##1 m_axis_tvalid |->
            m_axis_tdata[CH_LSB +: 2] == 2'($past(m_axis_tdata[CH_LSB +: 2]) + 2'd1))
        else $error("scan channel did not advance by one");

    // A level one sample leaves the temperatures and level two untouched.
    a_level_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_take ##1 (m_axis_tvalid && m_axis_tdata[CH_LSB +: 2] == CH_LEVEL_TWO) |->
            m_axis_tdata[T_ONE_LSB +: TEMP_W] == $past(m_axis_tdata[T_ONE_LSB +: TEMP_W])
            && m_axis_tdata[T_TWO_LSB +: TEMP_W] == $past(m_axis_tdata[T_TWO_LSB +: TEMP_W])
            && m_axis_tdata[L_TWO_LSB +: LEVEL_W] == $past(m_axis_tdata[L_TWO_LSB +: LEVEL_W]))
        else $error("level one sample changed another channel");

endmodule

bind dual_heater_hysteresis_thermostat dhht_checker u_dhht_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
